FILE: hdl/vti_pkg.sv
package vti_pkg;

    localparam int SAMPLE_W = 16;
    localparam int FRAC_W   = 8;
    localparam int Q_SHIFT  = 3 * FRAC_W;
    localparam int VALUE_W  = 40;
    localparam int LX_W     = SAMPLE_W + FRAC_W + 1;
    localparam int LY_W     = LX_W + FRAC_W;
    localparam int IDX_W    = 2;
    localparam int CFG_W    = 16;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic        [FRAC_W-1:0]   frac_t;
    typedef logic        [FRAC_W:0]     weight_t;
    typedef logic signed [LX_W-1:0]     lerp_x_t;
    typedef logic signed [LY_W-1:0]     lerp_y_t;
    typedef logic signed [VALUE_W-1:0]  value_t;
    typedef logic        [IDX_W-1:0]    reg_idx_t;
    typedef logic        [CFG_W-1:0]    cfg_data_t;

    localparam weight_t ONE_FRAC = weight_t'(1 << FRAC_W);

    localparam reg_idx_t REG_INTERP_MODE  = 2'd0;
    localparam reg_idx_t REG_THREE_DIMS   = 2'd1;
    localparam reg_idx_t REG_OUTSIDE_VAL  = 2'd2;

    typedef struct packed {
        logic    interp_mode;
        logic    three_dims;
        sample_t outside_value;
    } cfg_t;

    typedef struct packed {
        logic    bypass;
        logic    was_outside;
        sample_t bypass_val;
        frac_t   fy;
        frac_t   fz;
        lerp_x_t a0;
        lerp_x_t a1;
        lerp_x_t a2;
        lerp_x_t a3;
    } x_stage_t;

    typedef struct packed {
        logic    bypass;
        logic    was_outside;
        sample_t bypass_val;
        frac_t   fz;
        lerp_y_t b0;
        lerp_y_t b1;
    } y_stage_t;

    function automatic weight_t complement(input frac_t f);
        complement = ONE_FRAC - {1'b0, f};
    endfunction

endpackage

FILE: hdl/vti_point_if.sv
interface vti_point_if;
    logic             valid;
    logic             ready;
    vti_pkg::sample_t sample_0;
    vti_pkg::sample_t sample_1;
    vti_pkg::sample_t sample_2;
    vti_pkg::sample_t sample_3;
    vti_pkg::sample_t sample_4;
    vti_pkg::sample_t sample_5;
    vti_pkg::sample_t sample_6;
    vti_pkg::sample_t sample_7;
    vti_pkg::frac_t   frac_x;
    vti_pkg::frac_t   frac_y;
    vti_pkg::frac_t   frac_z;
    logic             outside;

    modport source (
        output valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5,
               sample_6, sample_7, frac_x, frac_y, frac_z, outside,
        input  ready
    );
    modport sink (
        input  valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5,
               sample_6, sample_7, frac_x, frac_y, frac_z, outside,
        output ready
    );
endinterface

FILE: hdl/vti_result_if.sv
interface vti_result_if;
    logic            valid;
    logic            ready;
    vti_pkg::value_t value_q24;
    logic            was_outside;

    modport source (output valid, value_q24, was_outside, input ready);
    modport sink (input valid, value_q24, was_outside, output ready);
endinterface

FILE: hdl/vti_cfg_if.sv
interface vti_cfg_if;
    logic               valid;
    logic               ready;
    vti_pkg::reg_idx_t  index;
    vti_pkg::cfg_data_t data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/vti_cfg_regs.sv
module vti_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    vti_cfg_if.sink       cfg,
    output vti_pkg::cfg_t cfg_out
);

    vti_pkg::cfg_t cfg_reg;
    vti_pkg::cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_out   = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                vti_pkg::REG_INTERP_MODE: cfg_next.interp_mode   = cfg.data[0];
                vti_pkg::REG_THREE_DIMS:  cfg_next.three_dims    = cfg.data[0];
                vti_pkg::REG_OUTSIDE_VAL: cfg_next.outside_value = cfg.data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.interp_mode   <= 1'b1;
            cfg_reg.three_dims    <= 1'b1;
            cfg_reg.outside_value <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: hdl/vti_stage_x.sv
module vti_stage_x (
    input  logic              clk,
    input  logic              rst_n,
    input  vti_pkg::cfg_t     cfg,
    vti_point_if.sink         point,
    output logic              x_valid,
    output vti_pkg::x_stage_t x_data,
    input  logic              x_ready
);

    localparam int P_W = vti_pkg::SAMPLE_W + vti_pkg::FRAC_W + 2;

    logic              x_valid_reg;
    vti_pkg::x_stage_t x_data_reg;
    vti_pkg::x_stage_t x_data_next;

    logic signed [vti_pkg::FRAC_W+1:0] cx;
    logic signed [vti_pkg::FRAC_W+1:0] fx;
    logic signed [P_W-1:0] p0, p1, p2, p3, p4, p5, p6, p7;
    logic signed [P_W-1:0] s01, s23, s45, s67;

    assign cx = $signed({1'b0, vti_pkg::complement(point.frac_x)});
    assign fx = $signed({2'b00, point.frac_x});

    // lerp along x: even samples take the complement, odd ones the fraction
    assign p0 = point.sample_0 * cx;
    assign p1 = point.sample_1 * fx;
    assign p2 = point.sample_2 * cx;
    assign p3 = point.sample_3 * fx;
    assign p4 = point.sample_4 * cx;
    assign p5 = point.sample_5 * fx;
    assign p6 = point.sample_6 * cx;
    assign p7 = point.sample_7 * fx;
    assign s01 = p0 + p1;
    assign s23 = p2 + p3;
    assign s45 = p4 + p5;
    assign s67 = p6 + p7;

    always_comb
    begin
        x_data_next.bypass      = point.outside || !cfg.interp_mode;
        x_data_next.was_outside = point.outside;
        x_data_next.bypass_val  = point.outside ? cfg.outside_value : point.sample_0;
        x_data_next.fy          = point.frac_y;
        x_data_next.fz          = cfg.three_dims ? point.frac_z : '0;
        x_data_next.a0          = s01[vti_pkg::LX_W-1:0];
        x_data_next.a1          = s23[vti_pkg::LX_W-1:0];
        x_data_next.a2          = s45[vti_pkg::LX_W-1:0];
        x_data_next.a3          = s67[vti_pkg::LX_W-1:0];
    end

    assign point.ready = !x_valid_reg || x_ready;
    assign x_valid     = x_valid_reg;
    assign x_data      = x_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_valid_reg <= 1'b0;
        end
        else if (point.ready)
        begin
            x_valid_reg <= point.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (point.ready && point.valid)
        begin
            x_data_reg <= x_data_next;
        end
    end

endmodule

FILE: hdl/vti_stage_y.sv
module vti_stage_y (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              x_valid,
    input  vti_pkg::x_stage_t x_data,
    output logic              x_ready,
    output logic              y_valid,
    output vti_pkg::y_stage_t y_data,
    input  logic              y_ready
);

    localparam int P_W = vti_pkg::LX_W + vti_pkg::FRAC_W + 2;

    logic              y_valid_reg;
    vti_pkg::y_stage_t y_data_reg;
    vti_pkg::y_stage_t y_data_next;

    logic signed [vti_pkg::FRAC_W+1:0] cy;
    logic signed [vti_pkg::FRAC_W+1:0] fy;
    logic signed [P_W-1:0] q0, q1, q2, q3;
    logic signed [P_W-1:0] s01, s23;

    assign cy = $signed({1'b0, vti_pkg::complement(x_data.fy)});
    assign fy = $signed({2'b00, x_data.fy});

    assign q0  = x_data.a0 * cy;
    assign q1  = x_data.a1 * fy;
    assign q2  = x_data.a2 * cy;
    assign q3  = x_data.a3 * fy;
    assign s01 = q0 + q1;
    assign s23 = q2 + q3;

    always_comb
    begin
        y_data_next.bypass      = x_data.bypass;
        y_data_next.was_outside = x_data.was_outside;
        y_data_next.bypass_val  = x_data.bypass_val;
        y_data_next.fz          = x_data.fz;
        y_data_next.b0          = s01[vti_pkg::LY_W-1:0];
        y_data_next.b1          = s23[vti_pkg::LY_W-1:0];
    end

    assign x_ready = !y_valid_reg || y_ready;
    assign y_valid = y_valid_reg;
    assign y_data  = y_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_valid_reg <= 1'b0;
        end
        else if (x_ready)
        begin
            y_valid_reg <= x_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (x_ready && x_valid)
        begin
            y_data_reg <= y_data_next;
        end
    end

endmodule

FILE: hdl/vti_stage_z.sv
module vti_stage_z (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              y_valid,
    input  vti_pkg::y_stage_t y_data,
    output logic              y_ready,
    vti_result_if.source      result
);

    localparam int P_W = vti_pkg::LY_W + vti_pkg::FRAC_W + 2;

    logic            z_valid_reg;
    vti_pkg::value_t value_reg;
    vti_pkg::value_t value_next;
    logic            was_outside_reg;

    logic signed [vti_pkg::FRAC_W+1:0] cz;
    logic signed [vti_pkg::FRAC_W+1:0] fz;
    logic signed [P_W-1:0] r0, r1, sum;

    assign cz  = $signed({1'b0, vti_pkg::complement(y_data.fz)});
    assign fz  = $signed({2'b00, y_data.fz});
    assign r0  = y_data.b0 * cz;
    assign r1  = y_data.b1 * fz;
    assign sum = r0 + r1;

    // nearest and outside points carry a plain sample, scaled to the output format
    assign value_next = y_data.bypass
                      ? {y_data.bypass_val, {vti_pkg::Q_SHIFT{1'b0}}}
                      : sum[vti_pkg::VALUE_W-1:0];

    assign y_ready            = !z_valid_reg || result.ready;
    assign result.valid       = z_valid_reg;
    assign result.value_q24   = value_reg;
    assign result.was_outside = was_outside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z_valid_reg <= 1'b0;
        end
        else if (y_ready)
        begin
            z_valid_reg <= y_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (y_ready && y_valid)
        begin
            value_reg       <= value_next;
            was_outside_reg <= y_data.was_outside;
        end
    end

endmodule

FILE: hdl/voxel_trilinear_interpolator.sv
// Trilinear interpolator: takes one sampling point per cycle while ready is high
// (eight neighbor voxels, x/y/z fractions in 1/256 units and an outside flag) and
// returns one signed value with 24 fraction bits. The work is three register stages,
// one axis per stage (x, then y, then z): four linear blends in the x stage, two in
// the y stage and one in z, each a pair of multiplies and an add; the z stage is
// the output register. The sustained rate is one point per clock while the result
// is taken. Input ready drops only while all three stages hold data and the result
// is not being taken. Configuration writes are taken every cycle and should only be
// issued with the pipeline empty.
module voxel_trilinear_interpolator (
    input  logic          clk,
    input  logic          rst_n,
    vti_cfg_if.sink       cfg,
    vti_point_if.sink     point,
    vti_result_if.source  result
);

    vti_pkg::cfg_t     cfg_cur;
    logic              x_valid;
    logic              x_ready;
    vti_pkg::x_stage_t x_data;
    logic              y_valid;
    logic              y_ready;
    vti_pkg::y_stage_t y_data;

    vti_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_cur)
    );

    vti_stage_x u_stage_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_cur),
        .point   (point),
        .x_valid (x_valid),
        .x_data  (x_data),
        .x_ready (x_ready)
    );

    vti_stage_y u_stage_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .x_valid (x_valid),
        .x_data  (x_data),
        .x_ready (x_ready),
        .y_valid (y_valid),
        .y_data  (y_data),
        .y_ready (y_ready)
    );

    vti_stage_z u_stage_z (
        .clk     (clk),
        .rst_n   (rst_n),
        .y_valid (y_valid),
        .y_data  (y_data),
        .y_ready (y_ready),
        .result  (result)
    );

    // substituted values are whole numbers
    a_outside_whole: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.was_outside |-> result.value_q24[vti_pkg::Q_SHIFT-1:0] == '0)
        else $error("outside result has nonzero fraction bits");

    a_outside_value: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.was_outside
        |-> result.value_q24[vti_pkg::VALUE_W-1:vti_pkg::Q_SHIFT] == cfg_cur.outside_value)
        else $error("outside result does not match the configured value");

    // with the output register empty every stage can advance
    a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !result.valid |-> point.ready)
        else $error("point input stalled while the output register is empty");

endmodule
